/* rtl/osrb_pkg.sv */
package osrb_pkg;

  // Default ring depth in bytes
  localparam int unsigned DEF_RING_DEPTH = 256;

  // Operation codes carried by an input beat
  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_DROP  = 3'd2,
    OP_HLEN  = 3'd3,
    OP_CLEAR = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LOSS  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_ERROR = 2'd3
  } status_e;

  // Control sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_WALK = 1'b1
  } state_e;

  // What a memory walk is doing
  typedef enum logic [1:0] {
    W_EVICT = 2'd0,
    W_DROP  = 2'd1,
    W_HLEN  = 2'd2
  } walk_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic [8:0] string_length;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_byte;
    logic       last;
    logic [7:0] head_length;
    logic [6:0] fill_percent;
    logic       is_empty;
  } out_t;

  // Finished item waiting for its fill level and the output register
  typedef struct packed {
    logic [1:0] status;
    logic       is_pop;
    logic [7:0] head_length;
  } meta_t;

endpackage

/* rtl/osrb_fill.sv */
module osrb_fill import osrb_pkg::*; #(
  parameter int unsigned RING_DEPTH = DEF_RING_DEPTH
) (
  input  logic [$clog2(RING_DEPTH)-1:0] head_i,
  input  logic [$clog2(RING_DEPTH)-1:0] tail_i,
  input  logic                          empty_i,
  output logic [6:0]                    fill_o
);

  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  // Reciprocal scale: 2^SH exceeds RING_DEPTH squared, so the floor is exact
  localparam int unsigned SH = 2 * CW;
  localparam int unsigned MW = CW + 8;
  localparam int unsigned PW = CW + MW;
  localparam logic [63:0] RECIP =
    ((64'd100 << SH) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);

  logic [CW-1:0] occ;
  logic [PW-1:0] prod;

  // Occupied bytes, wrapping across the end of the store
  always_comb begin
    if (tail_i >= head_i) begin
      occ = CW'(tail_i - head_i);
    end else begin
      occ = CW'(RING_DEPTH) - CW'(head_i) + CW'(tail_i);
    end
  end

  assign prod = PW'(occ) * PW'(RECIP[MW-1:0]);

  // Empty reads 0, a full ring (head meets tail) reads 100
  always_comb begin
    if (empty_i) begin
      fill_o = 7'd0;
    end else if (occ == '0) begin
      fill_o = 7'd100;
    end else begin
      fill_o = 7'(prod >> SH);
    end
  end

endmodule

/* rtl/overwriting_string_ring_buffer.sv */
// Channel | Direction | Handshake             | Beat
// in      | input     | in_valid_i/in_stall_o  | in_t: operation, data_byte, string_length
// out     | output    | out_valid_o/out_stall_i| out_t: status, bytes, fill level, empty
//
// Push, pop, clear and refused beats finish without a walk: the next beat is
// taken once their result has left the staging register. Drop and head length
// walk the stored bytes one at a time, and a push that must evict walks stored
// bytes through the single read port of the byte store. Reset clears
// pointers and flags only; the store needs no clearing pass. A stalled output
// only blocks input once a second finished result is waiting behind it.
module overwriting_string_ring_buffer import osrb_pkg::*; #(
  parameter int unsigned RING_DEPTH = DEF_RING_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned SW = ((CW > 9) ? CW : 9) + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    r = (p == LAST_IDX) ? '0 : p + AW'(1);
    return r;
  endfunction

  // Byte store
  logic [7:0]    mem [RING_DEPTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata;
  logic [7:0]    rdata_q;

  // Control and pointer registers
  state_e        state_q, state_d;
  walk_e         mode_q, mode_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d, wp_q, wp_d;
  logic          empty_q, empty_d, refused_q, refused_d;
  logic [8:0]    left_q, left_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [7:0]    hl_q, hl_d, pbyte_q, pbyte_d;
  logic          m1_v_q, m1_v_d;
  meta_t         m1_q, m1_d, m1_new;
  logic          out_v_q, out_v_d;
  out_t          out_q, out_d;

  logic          in_acc, start_walk, walk_done, m1_load, m1_go;
  logic [AW-1:0] nxt_head, nxt_wp, evict_start;
  logic [8:0]    len;
  logic [7:0]    dbyte;
  logic [CW-1:0] free_sp;
  logic [SW-1:0] ev_sum;
  logic          len_big, len_over_free;
  logic [6:0]    fill;

  assign in_stall_o  = !((state_q == S_IDLE) && !m1_v_q);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  assign len      = in_data_i.string_length;
  assign dbyte    = in_data_i.data_byte;
  assign nxt_head = inc(head_q);
  assign nxt_wp   = inc(wp_q);

  // Free space and eviction start point for the first byte of a string
  always_comb begin
    if (empty_q) begin
      free_sp = CW'(RING_DEPTH);
    end else if (head_q >= tail_q) begin
      free_sp = CW'(head_q - tail_q);
    end else begin
      free_sp = CW'(RING_DEPTH) - CW'(tail_q) + CW'(head_q);
    end
    len_big       = SW'(len) > SW'(RING_DEPTH);
    len_over_free = SW'(len) > SW'(free_sp);
    ev_sum        = SW'(tail_q) + SW'(len) - SW'(1);
    if (ev_sum >= SW'(RING_DEPTH)) begin
      ev_sum = ev_sum - SW'(RING_DEPTH);
    end
    evict_start = AW'(ev_sum);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && start_walk) begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, memory access and result capture
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    empty_d    = empty_q;
    left_d     = left_q;
    refused_d  = refused_q;
    mode_d     = mode_q;
    wp_d       = wp_q;
    rem_d      = rem_q;
    hl_d       = hl_q;
    pbyte_d    = pbyte_q;
    start_walk = 1'b0;
    walk_done  = 1'b0;
    m1_load    = 1'b0;
    m1_new     = '0;
    mem_we     = 1'b0;
    waddr      = tail_q;
    wdata      = '0;
    mem_re     = 1'b0;
    raddr      = head_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          m1_load = 1'b1;
          case (op_e'(in_data_i.operation))
            OP_PUSH: begin
              if (left_q == '0) begin
                if (len == '0) begin
                  m1_new.status = ST_ERROR;
                end else if (len_big) begin
                  // oversized string: swallow its remaining beats
                  refused_d     = 1'b1;
                  left_d        = len - 9'd1;
                  m1_new.status = ST_ERROR;
                end else begin
                  refused_d = 1'b0;
                  left_d    = len - 9'd1;
                  if (len_over_free) begin
                    // make room first, store once the walk ends
                    start_walk = 1'b1;
                    m1_load    = 1'b0;
                    mode_d     = W_EVICT;
                    wp_d       = evict_start;
                    rem_d      = CW'(SW'(RING_DEPTH) - SW'(len));
                    pbyte_d    = (len == 9'd1) ? 8'd0 : dbyte;
                    mem_re     = 1'b1;
                    raddr      = evict_start;
                  end else begin
                    mem_we  = 1'b1;
                    wdata   = (len == 9'd1) ? 8'd0 : dbyte;
                    tail_d  = inc(tail_q);
                    empty_d = 1'b0;
                  end
                end
              end else if (refused_q) begin
                left_d = left_q - 9'd1;
                if (left_q == 9'd1) begin
                  refused_d = 1'b0;
                end
                m1_new.status = ST_ERROR;
              end else begin
                mem_we  = 1'b1;
                wdata   = (left_q == 9'd1) ? 8'd0 : dbyte;
                tail_d  = inc(tail_q);
                empty_d = 1'b0;
                left_d  = left_q - 9'd1;
              end
            end
            OP_POP: begin
              if (empty_q) begin
                m1_new.status = ST_EMPTY;
              end else begin
                mem_re        = 1'b1;
                raddr         = head_q;
                head_d        = nxt_head;
                empty_d       = (nxt_head == tail_q);
                m1_new.is_pop = 1'b1;
              end
            end
            OP_DROP, OP_HLEN: begin
              if (empty_q) begin
                m1_new.status = ST_EMPTY;
              end else begin
                start_walk = 1'b1;
                m1_load    = 1'b0;
                mode_d     = (op_e'(in_data_i.operation) == OP_DROP) ? W_DROP : W_HLEN;
                wp_d       = head_q;
                hl_d       = '0;
                mem_re     = 1'b1;
                raddr      = head_q;
              end
            end
            OP_CLEAR: begin
              head_d    = '0;
              tail_d    = '0;
              empty_d   = 1'b1;
              left_d    = '0;
              refused_d = 1'b0;
            end
            default: begin
              m1_new.status = ST_ERROR;
            end
          endcase
        end
      end

      S_WALK: begin
        // rdata_q holds the byte at wp_q; fetch the following one meanwhile
        mem_re = 1'b1;
        raddr  = nxt_wp;
        case (mode_q)
          W_EVICT: begin
            if ((rdata_q == 8'd0) || (rem_q == '0)) begin
              walk_done     = 1'b1;
              head_d        = (rdata_q == 8'd0) ? nxt_wp : tail_q;
              mem_we        = 1'b1;
              wdata         = pbyte_q;
              tail_d        = inc(tail_q);
              empty_d       = 1'b0;
              m1_new.status = ST_LOSS;
            end else begin
              wp_d  = nxt_wp;
              rem_d = rem_q - CW'(1);
            end
          end
          W_DROP: begin
            if ((rdata_q == 8'd0) || (nxt_wp == tail_q)) begin
              walk_done = 1'b1;
              head_d    = nxt_wp;
              empty_d   = (nxt_wp == tail_q);
            end else begin
              wp_d = nxt_wp;
            end
          end
          W_HLEN: begin
            if (rdata_q == 8'd0) begin
              walk_done = 1'b1;
            end else begin
              hl_d = (hl_q == 8'hFF) ? hl_q : hl_q + 8'd1;
              if (nxt_wp == tail_q) begin
                walk_done = 1'b1;
              end else begin
                wp_d = nxt_wp;
              end
            end
            m1_new.head_length = hl_d;
          end
          default: begin
            walk_done = 1'b1;
          end
        endcase
        m1_load = walk_done;
      end

      default: ;
    endcase
  end

  // Fill level from the settled pointers
  osrb_fill #(
    .RING_DEPTH(RING_DEPTH)
  ) u_fill (
    .head_i (head_q),
    .tail_i (tail_q),
    .empty_i(empty_q),
    .fill_o (fill)
  );

  // Result staging: finished item, then output register
  assign m1_go = m1_v_q && (!out_v_q || !out_stall_i);

  always_comb begin
    m1_v_d = m1_v_q;
    m1_d   = m1_q;
    if (m1_load) begin
      m1_v_d = 1'b1;
      m1_d   = m1_new;
    end else if (m1_go) begin
      m1_v_d = 1'b0;
    end

    out_v_d = out_v_q;
    out_d   = out_q;
    if (m1_go) begin
      out_v_d            = 1'b1;
      out_d.status       = m1_q.status;
      out_d.read_byte    = m1_q.is_pop ? rdata_q : 8'd0;
      out_d.last         = m1_q.is_pop && (rdata_q == 8'd0);
      out_d.head_length  = m1_q.head_length;
      out_d.fill_percent = fill;
      out_d.is_empty     = empty_q;
    end else if (!out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mode_q    <= W_EVICT;
      head_q    <= '0;
      tail_q    <= '0;
      empty_q   <= 1'b1;
      left_q    <= '0;
      refused_q <= 1'b0;
      m1_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      empty_q   <= empty_d;
      left_q    <= left_d;
      refused_q <= refused_d;
      m1_v_q    <= m1_v_d;
      out_v_q   <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    wp_q    <= wp_d;
    rem_q   <= rem_d;
    hl_q    <= hl_d;
    pbyte_q <= pbyte_d;
    m1_q    <= m1_d;
    out_q   <= out_d;
  end

  // Byte store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

endmodule
